FILE: sv/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the age-counter page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

	// fixed field widths of the channels
	localparam int PAGE_IN_W = 20;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 32;
	localparam int ACT_W     = 5;

	// slot count in use after reset
	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	// control flags that ride along the search chain with a reference
	typedef struct packed {
		logic tok;    // a reference sits in this stage
		logic found;  // a valid slot matched the page
		logic empty;  // an empty slot has been seen
	} scan_flags_t;

	// update broadcast to every cell when a reference completes
	typedef struct packed {
		logic fire;   // apply the update this cycle
		logic fault;  // refill the chosen slot with the page
	} commit_t;

endpackage

FILE: sv/lpr_ifs.sv
// ----------------------------------------------------------------------------
// lpr channel interfaces
// Valid/ready channels for page references, results and slot count writes.
// ----------------------------------------------------------------------------
interface lpr_req_if;
	logic        valid;
	logic        ready;
	logic [19:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface lpr_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [3:0]  slot_used;
	logic [31:0] requests_so_far;
	logic [31:0] faults_so_far;

	modport source (output valid, output hit, output slot_used, output requests_so_far,
		output faults_so_far, input ready);
	modport sink   (input valid, input hit, input slot_used, input requests_so_far,
		input faults_so_far, output ready);
endinterface

interface lpr_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] active_entries;

	modport source (output valid, output active_entries, input ready);
	modport sink   (input valid, input active_entries, output ready);
endinterface

FILE: sv/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// One page slot: valid mark, tag and age, plus one stage of the search chain.
// ----------------------------------------------------------------------------
module lpr_cell #(
	parameter int IDX       = 0,
	parameter int IDX_W     = 4,
	parameter int NW        = 5,
	parameter int PAGE_BITS = 20,
	parameter int AGE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NW-1:0]         n_eff,
	input  logic                  adv,
	input  lpr_pkg::scan_flags_t  flags_in,
	input  logic [PAGE_BITS-1:0]  page_in,
	input  logic [IDX_W-1:0]      hit_idx_in,
	input  logic [IDX_W-1:0]      emp_idx_in,
	input  logic [IDX_W-1:0]      best_idx_in,
	input  logic [AGE_BITS-1:0]   best_age_in,
	output lpr_pkg::scan_flags_t  flags_out,
	output logic [PAGE_BITS-1:0]  page_out,
	output logic [IDX_W-1:0]      hit_idx_out,
	output logic [IDX_W-1:0]      emp_idx_out,
	output logic [IDX_W-1:0]      best_idx_out,
	output logic [AGE_BITS-1:0]   best_age_out,
	input  lpr_pkg::commit_t      cmt,
	input  logic [IDX_W-1:0]      cmt_idx,
	input  logic [PAGE_BITS-1:0]  cmt_page
);
	import lpr_pkg::*;

	localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(IDX);
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	logic                 valid_q;
	logic [PAGE_BITS-1:0] tag_q;
	logic [AGE_BITS-1:0]  age_q;

	scan_flags_t          flags_q, flags_d;
	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
	logic [IDX_W-1:0]     emp_idx_q, emp_idx_d;
	logic [IDX_W-1:0]     best_idx_q, best_idx_d;
	logic [AGE_BITS-1:0]  best_age_q, best_age_d;

	logic                 active;
	logic                 mine;
	logic [AGE_BITS-1:0]  aged;

	// slot takes part only below the count in use
	assign active = n_eff > NW'(IDX);
	assign mine   = cmt_idx == MY_IDX;
	assign aged   = (age_q == AGE_MAX) ? age_q : age_q + 1'b1;

	// search step: tag match, first empty slot, oldest slot so far
	always_comb begin
		flags_d    = flags_in;
		hit_idx_d  = hit_idx_in;
		emp_idx_d  = emp_idx_in;
		best_idx_d = best_idx_in;
		best_age_d = best_age_in;
		if (flags_in.tok && active) begin
			if (!flags_in.found && valid_q && tag_q == page_in) begin
				flags_d.found = 1'b1;
				hit_idx_d     = MY_IDX;
			end
			if (!flags_in.empty && !valid_q) begin
				flags_d.empty = 1'b1;
				emp_idx_d     = MY_IDX;
			end
			if (aged > best_age_in) begin
				best_age_d = aged;
				best_idx_d = MY_IDX;
			end
		end
	end

	// chain stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv) begin
			flags_q <= flags_d;
		end
	end

	// chain stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			page_q     <= page_in;
			hit_idx_q  <= hit_idx_d;
			emp_idx_q  <= emp_idx_d;
			best_idx_q <= best_idx_d;
			best_age_q <= best_age_d;
		end
	end

	// slot state: age every active slot, clear the chosen one, mark refill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (cmt.fire && active) begin
			age_q <= mine ? '0 : aged;
			if (cmt.fault && mine) begin
				valid_q <= 1'b1;
			end
		end
	end

	// tag refill
	always_ff @(posedge clk) begin
		if (cmt.fire && cmt.fault && mine) begin
			tag_q <= cmt_page;
		end
	end

	assign flags_out    = flags_q;
	assign page_out     = page_q;
	assign hit_idx_out  = hit_idx_q;
	assign emp_idx_out  = emp_idx_q;
	assign best_idx_out = best_idx_q;
	assign best_age_out = best_age_q;

endmodule

FILE: sv/lru_page_replacement_top.sv
// A reference accepted on the request channel walks through the chain of MAX_ENTRIES slot
// cells, one register each, and its result beat is then held in the output register.
// The block takes no new reference until the slots have been updated for the one in flight.
// A result beat waiting in the output register stalls the chain only when the next one is due.
// Reset: all slots empty with zero age, both counts zero, slot count 16; no clearing pass.
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// Page replacement by per-slot age counters, built as a chain of slot cells.
// ----------------------------------------------------------------------------
module lru_page_replacement_top #(
	parameter int MAX_ENTRIES = 16,
	parameter int PAGE_BITS   = 20,
	parameter int AGE_BITS    = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	lpr_req_if.sink    req,
	lpr_rsp_if.source  rsp,
	lpr_cfg_if.sink    cfg
);
	import lpr_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW    = ($clog2(MAX_ENTRIES + 1) > ACT_W) ? $clog2(MAX_ENTRIES + 1) : ACT_W;

	logic [ACT_W-1:0]  act_q;
	logic [NW-1:0]     n_eff;
	logic              busy_q;
	logic              adv;
	logic              take;
	logic [CNT_W-1:0]  req_cnt_q, req_cnt_d;
	logic [CNT_W-1:0]  flt_cnt_q, flt_cnt_d;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_req_q;
	logic [CNT_W-1:0]  out_flt_q;
	commit_t           cmt;
	logic [IDX_W-1:0]  used_idx;

	scan_flags_t          flags_c    [0:MAX_ENTRIES];
	logic [PAGE_BITS-1:0] page_c     [0:MAX_ENTRIES];
	logic [IDX_W-1:0]     hit_idx_c  [0:MAX_ENTRIES];
	logic [IDX_W-1:0]     emp_idx_c  [0:MAX_ENTRIES];
	logic [IDX_W-1:0]     best_idx_c [0:MAX_ENTRIES];
	logic [AGE_BITS-1:0]  best_age_c [0:MAX_ENTRIES];

	// slot count register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RESET;
		end else if (cfg.valid) begin
			act_q <= cfg.active_entries;
		end
	end

	// slot count clamped to 1..MAX_ENTRIES
	always_comb begin
		if (act_q == '0) begin
			n_eff = NW'(1);
		end else if (NW'(act_q) > NW'(MAX_ENTRIES)) begin
			n_eff = NW'(MAX_ENTRIES);
		end else begin
			n_eff = NW'(act_q);
		end
	end

	// input beat enters the head of the chain
	assign req.ready = !busy_q;
	assign take      = req.valid && !busy_q;

	always_comb begin
		flags_c[0]       = '0;
		flags_c[0].tok   = take;
		page_c[0]        = PAGE_BITS'(req.page_number);
		hit_idx_c[0]     = '0;
		emp_idx_c[0]     = '0;
		best_idx_c[0]    = '0;
		best_age_c[0]    = '0;
	end

	// the chain holds while a finished result cannot be handed over
	assign adv = !(flags_c[MAX_ENTRIES].tok && out_valid_q && !rsp.ready);

	// slot cells
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		lpr_cell #(
			.IDX       (g),
			.IDX_W     (IDX_W),
			.NW        (NW),
			.PAGE_BITS (PAGE_BITS),
			.AGE_BITS  (AGE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.n_eff        (n_eff),
			.adv          (adv),
			.flags_in     (flags_c[g]),
			.page_in      (page_c[g]),
			.hit_idx_in   (hit_idx_c[g]),
			.emp_idx_in   (emp_idx_c[g]),
			.best_idx_in  (best_idx_c[g]),
			.best_age_in  (best_age_c[g]),
			.flags_out    (flags_c[g+1]),
			.page_out     (page_c[g+1]),
			.hit_idx_out  (hit_idx_c[g+1]),
			.emp_idx_out  (emp_idx_c[g+1]),
			.best_idx_out (best_idx_c[g+1]),
			.best_age_out (best_age_c[g+1]),
			.cmt          (cmt),
			.cmt_idx      (used_idx),
			.cmt_page     (page_c[MAX_ENTRIES])
		);
	end

	// decision at the tail: hit slot, else first empty, else oldest
	always_comb begin
		cmt.fire  = flags_c[MAX_ENTRIES].tok && adv;
		cmt.fault = !flags_c[MAX_ENTRIES].found;
		if (flags_c[MAX_ENTRIES].found) begin
			used_idx = hit_idx_c[MAX_ENTRIES];
		end else if (flags_c[MAX_ENTRIES].empty) begin
			used_idx = emp_idx_c[MAX_ENTRIES];
		end else begin
			used_idx = best_idx_c[MAX_ENTRIES];
		end
	end

	// saturating counts
	assign req_cnt_d = (req_cnt_q == '1) ? req_cnt_q : req_cnt_q + 1'b1;
	assign flt_cnt_d = (cmt.fault && flt_cnt_q != '1) ? flt_cnt_q + 1'b1 : flt_cnt_q;

	// busy flag and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			req_cnt_q <= '0;
			flt_cnt_q <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (cmt.fire) begin
				busy_q <= 1'b0;
			end
			if (cmt.fire) begin
				req_cnt_q <= req_cnt_d;
				flt_cnt_q <= flt_cnt_d;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmt.fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmt.fire) begin
			out_hit_q  <= !cmt.fault;
			out_slot_q <= SLOT_W'(used_idx);
			out_req_q  <= req_cnt_d;
			out_flt_q  <= flt_cnt_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hit             = out_hit_q;
	assign rsp.slot_used       = out_slot_q;
	assign rsp.requests_so_far = out_req_q;
	assign rsp.faults_so_far   = out_flt_q;

endmodule

FILE: sv/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks of the page replacement block, bound to its top level.
// ----------------------------------------------------------------------------
module lpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_hit,
	input logic [3:0]  rsp_slot_used,
	input logic [31:0] rsp_requests_so_far,
	input logic [31:0] rsp_faults_so_far
);

	// a stalled result beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
			&& $stable(rsp_slot_used) && $stable(rsp_requests_so_far)
			&& $stable(rsp_faults_so_far))
		else $error("result beat changed while stalled");

	// faults never outnumber references
	a_flt_le_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_faults_so_far <= rsp_requests_so_far)
		else $error("fault count above request count");

	// one reference at a time: no beat taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("reference taken while one is in flight");

	// the very first reference always faults
	a_first_faults: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_requests_so_far == 32'd1 |-> !rsp_hit && rsp_faults_so_far == 32'd1)
		else $error("first reference did not fault");

endmodule

bind lru_page_replacement_top lpr_checker u_lpr_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_hit             (rsp.hit),
	.rsp_slot_used       (rsp.slot_used),
	.rsp_requests_so_far (rsp.requests_so_far),
	.rsp_faults_so_far   (rsp.faults_so_far)
);

FILE: tb/lru_page_replacement_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_top_tb
// Self-checking bench for the age-counter page replacement block. Page
// references go in over the request channel, and a local model of the slots,
// ages and counts predicts each result beat. The bench runs a directed
// opening, then random traces under several slot counts and idling mixes,
// with a long receiver hold-off.
// ----------------------------------------------------------------------------
module lru_page_replacement_top_tb;
	import lpr_pkg::*;

	localparam int SLOTS      = 16;
	localparam int LATENCY    = SLOTS + 1;
	localparam int STALL_MAX  = 2000;
	localparam int HOLD_LEN   = 300;
	localparam int HOT_DEPTH  = 24;

	// expected content of one result beat
	typedef struct packed {
		logic             hit;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0] reqs;
		logic [CNT_W-1:0] faults;
	} page_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	lpr_req_if req_ch();
	lpr_rsp_if rsp_ch();
	lpr_cfg_if cfg_ch();

	lru_page_replacement_top #(
		.MAX_ENTRIES(SLOTS),
		.PAGE_BITS  (PAGE_IN_W),
		.AGE_BITS   (CNT_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	always #2 clk = ~clk;

	// model of the slot store
	logic                 mdl_valid [SLOTS];
	logic [PAGE_IN_W-1:0] mdl_page  [SLOTS];
	logic [CNT_W-1:0]     mdl_age   [SLOTS];
	logic [CNT_W-1:0]     mdl_reqs;
	logic [CNT_W-1:0]     mdl_faults;
	logic [ACT_W-1:0]     mdl_count;

	page_outcome_t        outcome_q[$];
	logic [PAGE_IN_W-1:0] hot_pages [HOT_DEPTH];

	int  fail_count;
	int  src_idle_pct;
	int  snk_stall_pct;
	int  quiet_cycles;
	logic hold_on;
	event hold_kick;

	// one line per mismatch, and a tally
	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
	endtask

	function automatic int slots_live();
		if (mdl_count == 0)
			return 1;
		if (mdl_count > SLOTS)
			return SLOTS;
		return int'(mdl_count);
	endfunction

	// lru update for one accepted reference, queueing the beat it causes
	task automatic predict_reference(input logic [PAGE_IN_W-1:0] pg);
		int n;
		int used;
		bit found;
		bit empty_seen;
		logic [CNT_W-1:0] best;
		page_outcome_t o;
		n = slots_live();
		used = 0;
		found = 1'b0;
		empty_seen = 1'b0;
		if (mdl_reqs != '1)
			mdl_reqs++;
		for (int i = 0; i < n; i++) begin
			if (!found && mdl_valid[i] && mdl_page[i] == pg) begin
				found = 1'b1;
				used = i;
			end
			if (mdl_age[i] != '1)
				mdl_age[i]++;
		end
		if (!found) begin
			if (mdl_faults != '1)
				mdl_faults++;
			for (int i = 0; i < n; i++) begin
				if (!empty_seen && !mdl_valid[i]) begin
					used = i;
					empty_seen = 1'b1;
				end
			end
			// oldest slot, ties to the lowest index
			if (!empty_seen) begin
				used = 0;
				best = mdl_age[0];
				for (int i = 1; i < n; i++) begin
					if (mdl_age[i] > best) begin
						best = mdl_age[i];
						used = i;
					end
				end
			end
			mdl_valid[used] = 1'b1;
			mdl_page[used] = pg;
		end
		mdl_age[used] = '0;
		o.hit = found;
		o.slot = used[SLOT_W-1:0];
		o.reqs = mdl_reqs;
		o.faults = mdl_faults;
		outcome_q.push_back(o);
	endtask

	// one reference beat, with a random gap ahead of it
	task automatic send_page(input logic [PAGE_IN_W-1:0] pg);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page_number <= pg;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_reference(pg);
	endtask

	// stop offering and let every result beat come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [ACT_W-1:0] v);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.active_entries <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		mdl_count = v;
	endtask

	function automatic void refresh_hot_pages();
		for (int i = 0; i < HOT_DEPTH; i++)
			hot_pages[i] = PAGE_IN_W'($urandom);
	endfunction

	// mostly a working set a little larger than the live slots, some fresh pages
	function automatic logic [PAGE_IN_W-1:0] pick_page();
		int top;
		if ($urandom_range(0, 99) < 80) begin
			top = slots_live() + 3;
			if (top > HOT_DEPTH - 1)
				top = HOT_DEPTH - 1;
			return hot_pages[$urandom_range(0, top)];
		end
		return PAGE_IN_W'($urandom);
	endfunction

	task automatic send_trace(input int n);
		for (int i = 0; i < n; i++)
			send_page(pick_page());
	endtask

	// corners of the page field, hits, refills and resizing
	task automatic test_directed();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_page(20'h00000);
		send_page(20'hFFFFF);
		send_page(20'h00000);
		send_page(20'h55555);
		send_page(20'hAAAAA);
		send_page(20'hFFFFF);
		write_slot_count(5'd2);
		send_page(20'h12345);
		send_page(20'h00000);
		send_page(20'h12345);
		// zero acts as one slot
		write_slot_count(5'd0);
		send_page(20'h0F0F0);
		send_page(20'h0F0F0);
		send_page(20'hFFFFF);
		// over the top acts as the full store, hidden slots come back
		write_slot_count(5'd31);
		send_page(20'hAAAAA);
		send_page(20'h55555);
		send_page(20'h12345);
		write_slot_count(5'd17);
		send_page(20'h0F0F0);
		write_slot_count(5'd1);
		send_page(20'h54321);
		write_slot_count(5'd16);
		for (int i = 0; i < 5; i++)
			send_page(PAGE_IN_W'(20'h80000 + i));
	endtask

	task automatic test_idle_mix(input int idle, input int stall,
		input logic [ACT_W-1:0] cnt, input int n);
		write_slot_count(cnt);
		src_idle_pct = idle;
		snk_stall_pct = stall;
		refresh_hot_pages();
		send_trace(n);
	endtask

	// planned, then random slot counts between short bursts, keeping old slot contents
	task automatic test_resize_sweep();
		logic [ACT_W-1:0] plan [10] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3,
			5'd17, 5'd8, 5'd2, 5'd16, 5'd5};
		for (int k = 0; k < 16; k++) begin
			if (k < 10)
				write_slot_count(plan[k]);
			else
				write_slot_count(ACT_W'($urandom_range(0, 31)));
			src_idle_pct = $urandom_range(0, 1) ? 22 : 0;
			snk_stall_pct = $urandom_range(0, 1) ? 22 : 0;
			if (k == 8)
				refresh_hot_pages();
			send_trace(16);
		end
	endtask

	// receiver holds off while references keep coming
	task automatic test_backpressure();
		write_slot_count(5'd4);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		-> hold_kick;
		send_trace(40);
	endtask

	// receiver ready, with the long hold-off on top
	always @(posedge clk) begin
		if (hold_on)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// hold-off counter
	initial begin
		hold_on <= 1'b0;
		forever begin
			@(hold_kick);
			@(posedge clk);
			hold_on <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (outcome_q.size() == 0) begin
				flag_mismatch("result beat with none expected", rsp_ch.requests_so_far, 0);
			end else begin
				want = outcome_q.pop_front();
				if (rsp_ch.hit !== want.hit)
					flag_mismatch("hit", 32'(rsp_ch.hit), 32'(want.hit));
				if (rsp_ch.slot_used !== want.slot)
					flag_mismatch("slot_used", 32'(rsp_ch.slot_used), 32'(want.slot));
				if (rsp_ch.requests_so_far !== want.reqs)
					flag_mismatch("requests_so_far", rsp_ch.requests_so_far, want.reqs);
				if (rsp_ch.faults_so_far !== want.faults)
					flag_mismatch("faults_so_far", rsp_ch.faults_so_far, want.faults);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.page_number <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.active_entries <= '0;
		quiet_cycles <= 0;
		fail_count = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		for (int i = 0; i < SLOTS; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_page[i] = '0;
			mdl_age[i] = '0;
		end
		mdl_reqs = '0;
		mdl_faults = '0;
		mdl_count = ACT_RESET;
		refresh_hot_pages();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_idle_mix(0, 0, 5'd16, 150);
		test_idle_mix(54, 0, ACT_W'($urandom_range(1, 16)), 150);
		test_idle_mix(0, 54, ACT_W'($urandom_range(1, 16)), 150);
		test_idle_mix(22, 22, 5'd16, 150);
		test_resize_sweep();
		test_backpressure();

		drain_results();
		if (outcome_q.size() != 0)
			flag_mismatch("result beats never delivered", outcome_q.size(), 0);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
